// ===== rtl/swhc_pkg.sv =====
// Package for the sliding window hit counter.
// Holds the controller states, the command and status structs and shared constants.
// No dependencies.
`default_nettype none

package swhc_pkg;

	localparam int unsigned TS_W  = 31;
	localparam int unsigned CNT_W = 32;
	localparam int unsigned WIN_W = 10;

	localparam logic [WIN_W-1:0] WINDOW_RESET = 10'd300;
	localparam logic [CNT_W-1:0] COUNT_MAX    = 32'hFFFF_FFFF;

	// Func codes of an input item
	localparam logic FUNC_HIT   = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Register address of the window length
	localparam logic [1:0] ADDR_WINDOW = 2'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_HEAD,
		ST_CHK_HEAD,
		ST_HIT,
		ST_CHK_NEW,
		ST_DONE
	} swhc_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;     // capture item, compute retire limit
		logic rd_head;  // read oldest bucket
		logic rd_new;   // read newest bucket
		logic retire;   // drop oldest bucket from the total
		logic bump;     // add one to newest bucket
		logic push;     // open a new bucket with count one
	} swhc_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic query;     // latched item is a query
		logic occ_zero;  // ring empty
		logic head_old;  // read bucket lies at or below the limit
		logic new_match; // read bucket carries the item's timestamp
		logic ring_full; // every slot occupied
	} swhc_status_t;

	// Increment that holds at the top of the range
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/swhc_ctrl.sv =====
// Controller of the sliding window hit counter.
// Sequences retirement, hit recording and result delivery; uses swhc_pkg.
`default_nettype none

module swhc_ctrl
	import swhc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire swhc_status_t sts,
	output swhc_cmd_t         cmd,
	output logic              busy,
	output logic              done
);

	swhc_state_t state_q;
	swhc_state_t state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_RD_HEAD;
				end
			end
			ST_RD_HEAD: begin
				if (sts.occ_zero) begin
					state_d = ST_HIT;
				end else begin
					cmd.rd_head = 1'b1;
					state_d     = ST_CHK_HEAD;
				end
			end
			ST_CHK_HEAD: begin
				if (sts.head_old) begin
					cmd.retire = 1'b1;
					state_d    = ST_RD_HEAD;
				end else begin
					state_d = ST_HIT;
				end
			end
			ST_HIT: begin
				if (sts.query) begin
					state_d = ST_DONE;
				end else if (sts.occ_zero) begin
					cmd.push = 1'b1;
					state_d  = ST_DONE;
				end else begin
					cmd.rd_new = 1'b1;
					state_d    = ST_CHK_NEW;
				end
			end
			ST_CHK_NEW: begin
				if (sts.new_match || sts.ring_full) begin
					cmd.bump = 1'b1;
				end else begin
					cmd.push = 1'b1;
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

`default_nettype wire

// ===== rtl/swhc_datapath.sv =====
// Datapath of the sliding window hit counter.
// Holds the bucket memory, ring pointers, running total and window register; uses swhc_pkg.
`default_nettype none

module swhc_datapath
	import swhc_pkg::*;
#(
	parameter int unsigned BUCKETS = 512
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire swhc_cmd_t        cmd,
	output swhc_status_t          sts,
	input  wire logic             func,
	input  wire logic [TS_W-1:0]  timestamp,
	input  wire logic             win_we,
	input  wire logic [WIN_W-1:0] win_wdata,
	output logic [WIN_W-1:0]      window,
	output logic [CNT_W-1:0]      hit_count
);

	localparam int unsigned IDX_W = $clog2(BUCKETS);
	localparam int unsigned OCC_W = $clog2(BUCKETS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKETS - 1);
	localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(BUCKETS);

	typedef struct packed {
		logic [TS_W-1:0]  t;
		logic [CNT_W-1:0] hits;
	} bucket_t;

	bucket_t            mem [BUCKETS];
	bucket_t            rd_q;
	logic [WIN_W-1:0]   window_q;
	logic [IDX_W-1:0]   head_q;
	logic [IDX_W-1:0]   tail_q;
	logic [OCC_W-1:0]   occ_q;
	logic [CNT_W-1:0]   total_q;
	logic [TS_W-1:0]    ts_q;
	logic               func_q;
	logic signed [31:0] limit_q;

	logic [IDX_W-1:0]   newest;
	logic [IDX_W-1:0]   head_nx;
	logic [IDX_W-1:0]   tail_nx;
	logic [IDX_W-1:0]   rd_addr;
	logic               mem_we;
	logic [IDX_W-1:0]   wr_addr;
	bucket_t            wr_data;

	// Ring neighbours
	assign newest  = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;
	assign head_nx = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_nx = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;

	// Window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (win_we) begin
			window_q <= win_wdata;
		end
	end

	// Capture the item and its retire limit
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ts_q    <= timestamp;
			func_q  <= func;
			limit_q <= $signed({1'b0, timestamp}) - $signed({22'd0, window_q});
		end
	end

	// Bucket memory: one read port, one write port
	assign rd_addr = cmd.rd_head ? head_q : newest;
	assign mem_we  = cmd.push | cmd.bump;
	assign wr_addr = cmd.push ? tail_q : newest;
	always_comb begin
		if (cmd.push) begin
			wr_data.t    = ts_q;
			wr_data.hits = CNT_W'(1);
		end else begin
			wr_data.t    = rd_q.t;
			wr_data.hits = sat_inc(rd_q.hits);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_head || cmd.rd_new) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Ring pointers, fill count and running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
			total_q <= '0;
		end else begin
			if (cmd.retire) begin
				head_q  <= head_nx;
				occ_q   <= occ_q - 1'b1;
				total_q <= (total_q >= rd_q.hits) ? total_q - rd_q.hits : '0;
			end else if (cmd.push) begin
				tail_q  <= tail_nx;
				occ_q   <= occ_q + 1'b1;
				total_q <= sat_inc(total_q);
			end else if (cmd.bump) begin
				total_q <= sat_inc(total_q);
			end
		end
	end

	// Status to the controller
	assign sts.query     = (func_q == FUNC_QUERY);
	assign sts.occ_zero  = (occ_q == '0);
	assign sts.head_old  = ($signed({1'b0, rd_q.t}) <= limit_q);
	assign sts.new_match = (rd_q.t == ts_q);
	assign sts.ring_full = (occ_q == FULL_OCC);

	assign window    = window_q;
	assign hit_count = total_q;

endmodule

`default_nettype wire

// ===== rtl/sliding_window_hit_counter.sv =====
// Top level of the sliding window hit counter.
// Joins the APB register port, swhc_ctrl and swhc_datapath; uses swhc_pkg.
//
//   channel   signals                               handshake
//   config    psel penable pwrite paddr pwdata      APB, pready always high
//             prdata pready
//   item in   func timestamp                        start, taken when busy is low
//   result    hit_count                             done, one cycle, no stall
//
// Once an item is accepted, the controller reads and checks the oldest bucket,
// retiring it and reading the next while it lies at or below the retire limit;
// a hit then reads and checks the newest bucket unless the ring is left empty.
// The single read port of the bucket memory sets this retire loop.
// Reset clears the ring pointers, fill count and total; the window resets to 300.
// The bucket memory is not cleared: only occupied entries are ever read.
// busy stays high until the cycle after done.
`default_nettype none

module sliding_window_hit_counter
	import swhc_pkg::*;
#(
	parameter int unsigned BUCKETS = 512
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [1:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  wire logic             start,
	input  wire logic             func,
	input  wire logic [TS_W-1:0]  timestamp,
	output logic                  busy,
	output logic                  done,
	output logic [CNT_W-1:0]      hit_count
);

	swhc_cmd_t        cmd;
	swhc_status_t     sts;
	logic             win_we;
	logic [WIN_W-1:0] window;

	// Register port decode
	assign pready = 1'b1;
	assign win_we = psel & penable & pwrite & (paddr == ADDR_WINDOW);
	assign prdata = (paddr == ADDR_WINDOW) ? {22'd0, window} : '0;

	swhc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	swhc_datapath #(
		.BUCKETS (BUCKETS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.func      (func),
		.timestamp (timestamp),
		.win_we    (win_we),
		.win_wdata (pwdata[WIN_W-1:0]),
		.window    (window),
		.hit_count (hit_count)
	);

endmodule

`default_nettype wire

// ===== bench/window_count_checker.sv =====
// Checker for the sliding window hit counter: follows the register port and both item
// channels, keeps its own bucket ring, predicts each hit_count and compares.
// Depends on swhc_pkg for widths, codes and the register address.

module window_count_checker
	import swhc_pkg::*;
#(
	parameter int unsigned BUCKETS = 512
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [1:0]       paddr,
	input  wire logic [31:0]      pwdata,
	input  wire logic [31:0]      prdata,
	input  wire logic             pready,
	input  wire logic             start,
	input  wire logic             busy,
	input  wire logic             func,
	input  wire logic [TS_W-1:0]  timestamp,
	input  wire logic             done,
	input  wire logic [CNT_W-1:0] hit_count,
	output int                    mismatches,
	output int                    pending
);

	logic [TS_W-1:0]  slot_time [BUCKETS];
	logic [CNT_W-1:0] slot_hits [BUCKETS];
	int unsigned      oldest;
	int unsigned      free_slot;
	int unsigned      filled;
	logic [CNT_W-1:0] total;
	logic [WIN_W-1:0] window_len;
	logic [CNT_W-1:0] due_counts [$];
	int               fault_count;

	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// Advance the ring by one item and return the total it leaves behind
	function automatic logic [CNT_W-1:0] predict_count(input logic op,
			input logic [TS_W-1:0] ts);
		longint      horizon;
		int unsigned newest;
		horizon = longint'(ts) - longint'(window_len);
		// drop buckets that have slid out of the window, oldest first
		while (filled > 0 && longint'(slot_time[oldest]) <= horizon) begin
			total  = (total >= slot_hits[oldest]) ? total - slot_hits[oldest] : '0;
			oldest = (oldest + 1 == BUCKETS) ? 0 : oldest + 1;
			filled--;
		end
		if (op == FUNC_HIT) begin
			newest = (free_slot == 0) ? BUCKETS - 1 : free_slot - 1;
			// bump the newest bucket on a repeated second or a full ring, else open one
			if (filled > 0 && (slot_time[newest] == ts || filled >= BUCKETS)) begin
				slot_hits[newest] = count_up(slot_hits[newest]);
			end else begin
				slot_time[free_slot] = ts;
				slot_hits[free_slot] = CNT_W'(1);
				free_slot = (free_slot + 1 == BUCKETS) ? 0 : free_slot + 1;
				filled++;
			end
			total = count_up(total);
		end
		return total;
	endfunction

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t: mismatch: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [CNT_W-1:0] want;
		if (!arst_n) begin
			oldest      = 0;
			free_slot   = 0;
			filled      = 0;
			total       = '0;
			window_len  = WINDOW_RESET;
			fault_count = 0;
			due_counts.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			// follow the window register and check read-back
			if (psel && penable && pready && paddr == ADDR_WINDOW) begin
				if (pwrite)
					window_len = pwdata[WIN_W-1:0];
				else if (prdata[WIN_W-1:0] !== window_len)
					note_fault($sformatf("window read expected %0d, got %0d",
						window_len, prdata[WIN_W-1:0]));
			end
			// compare each result with the oldest outstanding item
			if (done) begin
				if (due_counts.size() == 0) begin
					note_fault($sformatf("hit_count %0d with no item outstanding", hit_count));
				end else begin
					want = due_counts[0];
					due_counts.delete(0);
					if (hit_count !== want)
						note_fault($sformatf("hit_count expected %0d, got %0d",
							want, hit_count));
				end
			end
			// predict each accepted item
			if (start && !busy)
				due_counts.push_back(predict_count(func, timestamp));
			mismatches <= fault_count;
			pending    <= due_counts.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
// Top of the sliding window hit counter bench: clock, reset, register writes and item
// traffic, with the verdict at the end. Depends on swhc_pkg, the block and
// window_count_checker.

module tb
	import swhc_pkg::*;
();

	localparam int unsigned BUCKETS = 512;
	localparam logic [TS_W-1:0] TS_TOP = '1;

	logic             clk;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [1:0]       paddr;
	logic [31:0]      pwdata;
	logic [31:0]      prdata;
	logic             pready;
	logic             start;
	logic             func;
	logic [TS_W-1:0]  timestamp;
	logic             busy;
	logic             done;
	logic [CNT_W-1:0] hit_count;
	int               mismatches;
	int               pending;

	logic [TS_W-1:0]  now_ts;
	logic [WIN_W-1:0] window_len;
	int               items_sent;

	sliding_window_hit_counter #(.BUCKETS(BUCKETS)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .func(func), .timestamp(timestamp),
		.busy(busy), .done(done), .hit_count(hit_count)
	);

	window_count_checker #(.BUCKETS(BUCKETS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .func(func), .timestamp(timestamp),
		.done(done), .hit_count(hit_count),
		.mismatches(mismatches), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Offer one item, holding start low in a random share of cycles, until it is taken
	task automatic issue(input logic op, input logic [TS_W-1:0] ts);
		int idle_pct;
		bit taken;
		idle_pct = (items_sent < 385) ? 27 : (items_sent < 770) ? 84 : 0;
		taken = 1'b0;
		func      <= op;
		timestamp <= ts;
		while (!taken) begin
			start <= ($urandom_range(0, 99) >= idle_pct);
			@(posedge clk);
			taken = start && !busy;
		end
		items_sent++;
	endtask

	// Hold off until every result is in and the block is idle
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
	endtask

	// Write the window register, then read it back
	task automatic set_window(input logic [WIN_W-1:0] w);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_WINDOW;
		pwdata  <= {22'($urandom()), w};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		window_len = w;
	endtask

	// Empty the ring, then move to a new window and starting time
	task automatic begin_phase(input logic [WIN_W-1:0] w, input logic [TS_W-1:0] from_ts);
		settle();
		set_window('0);
		issue(FUNC_QUERY, TS_TOP);
		settle();
		set_window(w);
		now_ts = from_ts;
	endtask

	// Random traffic: mostly forward time with bursts in one second, some long jumps
	// and some time running back; a dense mode steps a second at a time to fill the ring
	task automatic run_traffic(input int count, input bit dense);
		int pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (dense)
				now_ts += TS_W'((pick < 97) ? 1 : 0);
			else if (pick < 30)
				now_ts += TS_W'(0);
			else if (pick < 62)
				now_ts += TS_W'($urandom_range(1, 3));
			else if (pick < 84)
				now_ts += TS_W'($urandom_range(1, window_len / 2 + 1));
			else if (pick < 93)
				now_ts += TS_W'($urandom_range(window_len, 2 * window_len + 2));
			else if (pick < 97)
				now_ts += TS_W'($urandom_range(0, 1 << 20));
			else
				now_ts -= TS_W'($urandom_range(1, window_len + 4));
			issue(($urandom_range(0, 99) < (dense ? 3 : 30)) ? FUNC_QUERY : FUNC_HIT, now_ts);
			// now and then let the block drain completely
			if ($urandom_range(0, 199) == 0)
				settle();
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		start      = 1'b0;
		func       = FUNC_HIT;
		timestamp  = '0;
		items_sent = 0;
		now_ts     = '0;
		window_len = WINDOW_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window: bump, push, retire on the boundary, time running back
		issue(FUNC_QUERY, '0);
		issue(FUNC_HIT, 31'd1);
		issue(FUNC_HIT, 31'd1);
		issue(FUNC_HIT, 31'd2);
		issue(FUNC_QUERY, 31'd300);
		issue(FUNC_QUERY, 31'd301);
		issue(FUNC_HIT, 31'd302);
		issue(FUNC_HIT, 31'd150);
		issue(FUNC_QUERY, 31'd602);
		issue(FUNC_HIT, TS_TOP);
		issue(FUNC_HIT, TS_TOP);
		issue(FUNC_QUERY, TS_TOP);
		issue(FUNC_HIT, 31'd5);

		// zero window retires everything
		settle();
		set_window('0);
		issue(FUNC_QUERY, TS_TOP);
		issue(FUNC_HIT, TS_TOP);
		issue(FUNC_QUERY, TS_TOP);

		// one-second window
		settle();
		set_window(10'd1);
		issue(FUNC_HIT, 31'd10);
		issue(FUNC_HIT, 31'd11);
		issue(FUNC_HIT, 31'd11);
		issue(FUNC_QUERY, 31'd12);

		// window wider than the ring
		settle();
		set_window('1);
		issue(FUNC_HIT, 31'd100);
		issue(FUNC_HIT, 31'd1100);
		issue(FUNC_QUERY, 31'd1123);

		// random phases over several windows
		begin_phase(WIN_W'($urandom_range(2, 511)), 31'($urandom()));
		run_traffic(140, 1'b0);
		begin_phase(10'd512, 31'h7FFF_FF00);
		run_traffic(140, 1'b0);
		begin_phase(10'd1, 31'($urandom()));
		run_traffic(130, 1'b0);
		begin_phase(10'd0, 31'($urandom()));
		run_traffic(50, 1'b0);
		begin_phase('1, 31'($urandom_range(1, 1 << 30)));
		run_traffic(620, 1'b1);
		settle();
		set_window(WINDOW_RESET);
		run_traffic(50, 1'b0);

		settle();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Stop a hung run
	initial begin
		#(8 * 300000);
		$display("Regression FAIL");
		$finish;
	end

endmodule
